>>> src/fcas_pkg.sv
// Shared constants, register codes, stage records and fixed-point helpers for the
// friction circle acceleration selector. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcas_pkg;

  localparam int DW       = 32;
  localparam int FB       = 16;
  localparam int CW       = DW - 1;
  localparam int DIV_LAT  = DW;
  localparam int SQRT_LAT = DW;
  localparam int IDX_W    = 3;

  localparam logic [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};

  localparam longint EPS_RAW = ((longint'(1) << FB) + 500) / 1000;
  localparam logic [DW-1:0] EPS = (EPS_RAW == 0) ? DW'(1) : DW'(EPS_RAW);

  typedef enum logic [IDX_W-1:0] {
    REG_DIST_MODE = 3'd0,
    REG_MAX_ACCEL = 3'd1,
    REG_MAX_LONG  = 3'd2,
    REG_POWER     = 3'd3,
    REG_LAT_COEF  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                 vld;
    logic signed [DW-1:0] v;
    logic signed [DW-1:0] gs;
    logic                 lay_neg;
    logic                 last;
  } a_side_t;

  typedef struct packed {
    logic                   vld;
    logic signed [DW-1:0]   v;
    logic signed [DW-1:0]   gs;
    logic signed [DW-1:0]   lay;
    logic signed [DW-1:0]   capx;
    logic                   last;
    logic [2*DW-1:0]        gs2;
    logic [2*DW-1:0]        lay2;
    logic [2*DW-1:0]        vsq;
    logic [DW-1:0]          vv;
    logic [2*DW-1:0]        sum;
  } front_t;

  typedef struct packed {
    logic                   vld;
    logic signed [DW-1:0]   v;
    logic signed [DW-1:0]   gs;
    logic signed [DW-1:0]   lay;
    logic signed [DW-1:0]   capx;
    logic [DW-1:0]          capy;
    logic                   last;
    logic [DW-1:0]          root_c;
    logic                   low_norm;
    logic [2*DW-1:0]        pgx;
    logic [2*DW-1:0]        pgy;
    logic [2*DW-1:0]        capy_p;
    logic [2*DW-1:0]        a2;
    logic [2*DW-1:0]        cx2;
    logic [2*DW-1:0]        cy2;
    logic [2*DW-1:0]        rx;
    logic [2*DW-1:0]        ry;
  } mid_t;

  typedef struct packed {
    logic                   vld;
    logic signed [DW-1:0]   v;
    logic signed [DW-1:0]   capx;
    logic [DW-1:0]          capy;
    logic                   low_norm;
    logic                   last;
    logic signed [DW-1:0]   desx;
    logic signed [DW-1:0]   desy;
    logic [DW-1:0]          rdx;
    logic [DW-1:0]          rdy;
  } back_t;

  typedef struct packed {
    logic                   vld;
    logic signed [DW-1:0]   v;
    logic signed [DW-1:0]   num;
    logic signed [DW-1:0]   lng;
    logic                   zs;
    logic                   low_norm;
    logic                   last;
  } end_t;

  typedef struct packed {
    logic signed [DW-1:0] yaw;
    logic signed [DW-1:0] lng;
    logic                 zs;
    logic                 last;
  } out_t;

  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] a);
    return a[DW-1] ? DW'(-a) : a;
  endfunction

  function automatic logic signed [DW-1:0] sat_quo(input logic neg, input logic ovf,
                                                   input logic [DW-1:0] q);
    logic [DW:0] lim;
    logic [DW:0] mag;
    lim = neg ? ((DW+1)'(1) << (DW - 1)) : {1'b0, WMAX};
    mag = (ovf || ({1'b0, q} > lim)) ? lim : {1'b0, q};
    return neg ? DW'(-mag) : DW'(mag);
  endfunction

  function automatic logic [DW-1:0] sat_shr(input logic [2*DW-1:0] p);
    logic [2*DW-1:0] s;
    s = p >> FB;
    return (s > (2*DW)'(WMAX)) ? WMAX : s[DW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/friction_circle_accel_select.sv
// Top level of the friction circle acceleration selector: config registers,
// stage sequencing and output buffer. Depends on fcas_pkg, fcas_div, fcas_sqrt.
//
// One grid point enters per clock while in_ready is high, and its result is offered
// after passing through four chained 32-stage units (costate divide, norm square
// root, scaling divide with the friction-circle roots, yaw divide) plus the input
// register, nine arithmetic stages and the output buffer write. A two-entry output
// buffer lets the pipeline keep taking points while a result waits; with out_ready
// held high the rate is one transaction per cycle. Configuration is to be written
// only while the pipeline is empty; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module friction_circle_accel_select (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [fcas_pkg::DW-1:0]   in_speed,
  input  logic signed [fcas_pkg::DW-1:0]   in_grad_heading,
  input  logic signed [fcas_pkg::DW-1:0]   in_grad_speed,
  input  logic                             in_last_point,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [fcas_pkg::DW-1:0]   out_yaw_rate,
  output logic signed [fcas_pkg::DW-1:0]   out_long_accel,
  output logic                             out_zero_speed,
  output logic                             out_last_out,
  input  logic                             cfg_wr_en,
  input  logic [fcas_pkg::IDX_W-1:0]       cfg_index,
  input  logic [fcas_pkg::CW-1:0]          cfg_wdata
);
  import fcas_pkg::*;

  logic          dist_mode_r;
  logic [CW-1:0] max_accel_r;
  logic [CW-1:0] max_long_r;
  logic [CW-1:0] power_r;
  logic [CW-1:0] lat_coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_mode_r <= 1'b0;
      max_accel_r <= '0;
      max_long_r  <= '0;
      power_r     <= '0;
      lat_coef_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DIST_MODE: dist_mode_r <= cfg_wdata[0];
        REG_MAX_ACCEL: max_accel_r <= cfg_wdata;
        REG_MAX_LONG:  max_long_r  <= cfg_wdata;
        REG_POWER:     power_r     <= cfg_wdata;
        REG_LAT_COEF:  lat_coef_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic       en;
  logic [1:0] cnt_r;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  // Input stage.
  a_side_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
    end else if (en) begin
      s0_r.vld     <= in_valid;
      s0_r.v       <= in_speed;
      s0_r.gs      <= in_grad_speed;
      s0_r.lay_neg <= in_grad_heading[DW-1] ^ in_speed[DW-1];
      s0_r.last    <= in_last_point;
    end
  end

  logic signed [DW-1:0] gh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gh_r <= in_grad_heading;
    end
  end

  // Costate and power cap divisions.
  logic [DW-1:0] q_lay, q_cx;
  logic          ov_lay, ov_cx;

  fcas_div u_div_lay (
    .clk      (clk),
    .en       (en),
    .dividend ((2*DW)'(mag_of(gh_r)) << FB),
    .divisor  (mag_of(s0_r.v)),
    .quo      (q_lay),
    .ovf      (ov_lay)
  );

  fcas_div u_div_capx (
    .clk      (clk),
    .en       (en),
    .dividend ((2*DW)'(power_r) << FB),
    .divisor  (mag_of(s0_r.v)),
    .quo      (q_cx),
    .ovf      (ov_cx)
  );

  a_side_t a_pipe_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) a_pipe_r[i] <= '0;
    end else if (en) begin
      a_pipe_r[0] <= s0_r;
      for (int i = 1; i < DIV_LAT; i++) a_pipe_r[i] <= a_pipe_r[i-1];
    end
  end

  // Saturate quotients, squares, norm radicand.
  front_t               s1_r, s2_r, s3_r;
  front_t               s1_nxt, s2_nxt, s3_nxt;
  a_side_t              a_last;
  logic signed [DW-1:0] cx_full;
  logic signed [DW-1:0] ml;

  assign a_last  = a_pipe_r[DIV_LAT-1];
  assign cx_full = sat_quo(a_last.v[DW-1], ov_cx, q_cx);
  assign ml      = $signed({1'b0, max_long_r});

  always_comb begin
    s1_nxt      = '0;
    s1_nxt.vld  = a_last.vld;
    s1_nxt.v    = a_last.v;
    s1_nxt.gs   = a_last.gs;
    s1_nxt.last = a_last.last;
    s1_nxt.lay  = sat_quo(a_last.lay_neg, ov_lay, q_lay);
    s1_nxt.capx = (ml < cx_full) ? ml : cx_full;

    s2_nxt      = s1_r;
    s2_nxt.gs2  = (2*DW)'(mag_of(s1_r.gs)) * (2*DW)'(mag_of(s1_r.gs));
    s2_nxt.lay2 = (2*DW)'(mag_of(s1_r.lay)) * (2*DW)'(mag_of(s1_r.lay));
    s2_nxt.vsq  = (2*DW)'(mag_of(s1_r.v)) * (2*DW)'(mag_of(s1_r.v));

    s3_nxt      = s2_r;
    s3_nxt.sum  = s2_r.gs2 + s2_r.lay2;
    s3_nxt.vv   = sat_shr(s2_r.vsq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  // Gradient norm.
  logic [DW-1:0] root_raw;

  fcas_sqrt u_sqrt_norm (
    .clk  (clk),
    .en   (en),
    .rad  (s3_r.sum),
    .root (root_raw)
  );

  front_t b_pipe_r [SQRT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_LAT; i++) b_pipe_r[i] <= '0;
    end else if (en) begin
      b_pipe_r[0] <= s3_r;
      for (int i = 1; i < SQRT_LAT; i++) b_pipe_r[i] <= b_pipe_r[i-1];
    end
  end

  // Scaling products, lateral cap and friction circle radicands.
  mid_t          s4_r, s5_r, s6_r, s7_r;
  mid_t          s4_nxt, s5_nxt, s6_nxt, s7_nxt;
  front_t        b_last;
  logic [DW-1:0] root_c;

  assign b_last = b_pipe_r[SQRT_LAT-1];
  assign root_c = (root_raw > WMAX) ? WMAX : root_raw;

  always_comb begin
    s4_nxt          = '0;
    s4_nxt.vld      = b_last.vld;
    s4_nxt.v        = b_last.v;
    s4_nxt.gs       = b_last.gs;
    s4_nxt.lay      = b_last.lay;
    s4_nxt.capx     = b_last.capx;
    s4_nxt.last     = b_last.last;
    s4_nxt.root_c   = root_c;
    s4_nxt.low_norm = root_c < EPS;
    s4_nxt.pgx      = (2*DW)'(mag_of(b_last.gs)) * (2*DW)'(max_accel_r);
    s4_nxt.pgy      = (2*DW)'(mag_of(b_last.lay)) * (2*DW)'(max_accel_r);
    s4_nxt.capy_p   = (2*DW)'(lat_coef_r) * (2*DW)'(b_last.vv);

    s5_nxt          = s4_r;
    s5_nxt.capy     = sat_shr(s4_r.capy_p);
    s5_nxt.a2       = (2*DW)'(max_accel_r) * (2*DW)'(max_accel_r);
    s5_nxt.cx2      = (2*DW)'(mag_of(s4_r.capx)) * (2*DW)'(mag_of(s4_r.capx));

    s6_nxt          = s5_r;
    s6_nxt.cy2      = (2*DW)'(s5_r.capy) * (2*DW)'(s5_r.capy);

    s7_nxt          = s6_r;
    s7_nxt.rx       = (s6_r.cx2 >= s6_r.a2) ? '0 : s6_r.a2 - s6_r.cx2;
    s7_nxt.ry       = (s6_r.cy2 >= s6_r.a2) ? '0 : s6_r.a2 - s6_r.cy2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r <= '0;
      s5_r <= '0;
      s6_r <= '0;
      s7_r <= '0;
    end else if (en) begin
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
    end
  end

  // Desired direction and friction circle roots.
  logic [DW-1:0] q_dx, q_dy, rdx, rdy;
  logic          ov_dx, ov_dy;

  fcas_div u_div_desx (
    .clk      (clk),
    .en       (en),
    .dividend (s7_r.pgx),
    .divisor  (s7_r.root_c),
    .quo      (q_dx),
    .ovf      (ov_dx)
  );

  fcas_div u_div_desy (
    .clk      (clk),
    .en       (en),
    .dividend (s7_r.pgy),
    .divisor  (s7_r.root_c),
    .quo      (q_dy),
    .ovf      (ov_dy)
  );

  fcas_sqrt u_sqrt_rdx (
    .clk  (clk),
    .en   (en),
    .rad  (s7_r.rx),
    .root (rdx)
  );

  fcas_sqrt u_sqrt_rdy (
    .clk  (clk),
    .en   (en),
    .rad  (s7_r.ry),
    .root (rdy)
  );

  mid_t c_pipe_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) c_pipe_r[i] <= '0;
    end else if (en) begin
      c_pipe_r[0] <= s7_r;
      for (int i = 1; i < DIV_LAT; i++) c_pipe_r[i] <= c_pipe_r[i-1];
    end
  end

  mid_t  c_last;
  back_t s8_r;
  end_t  s9_r;
  logic  flip;

  assign c_last = c_pipe_r[DIV_LAT-1];
  assign flip   = !dist_mode_r;

  // Clip against the caps.
  logic [DW-1:0]        ady;
  logic [DW-1:0]        cy_sel;
  logic signed [DW-1:0] num_nxt;
  logic signed [DW-1:0] lng_nxt;

  always_comb begin
    ady     = mag_of(s8_r.desy);
    cy_sel  = s8_r.capy;
    num_nxt = s8_r.desy;
    lng_nxt = s8_r.capx;
    if (s8_r.desx > s8_r.capx) begin
      if ((ady < s8_r.capy) && (s8_r.rdx < s8_r.capy)) begin
        cy_sel = s8_r.rdx;
      end
      num_nxt = s8_r.desy[DW-1] ? -$signed(cy_sel) : $signed(cy_sel);
    end else if (ady > s8_r.capy) begin
      num_nxt = s8_r.desy[DW-1] ? -$signed(s8_r.capy) : $signed(s8_r.capy);
      if (s8_r.desx > 0) begin
        if ($signed(s8_r.rdy) < s8_r.capx) begin
          lng_nxt = $signed(s8_r.rdy);
        end
      end else begin
        lng_nxt = -$signed(s8_r.rdy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_r <= '0;
      s9_r <= '0;
    end else if (en) begin
      s8_r.vld      <= c_last.vld;
      s8_r.v        <= c_last.v;
      s8_r.capx     <= c_last.capx;
      s8_r.capy     <= c_last.capy;
      s8_r.low_norm <= c_last.low_norm;
      s8_r.last     <= c_last.last;
      s8_r.desx     <= sat_quo(c_last.gs[DW-1] != flip, ov_dx, q_dx);
      s8_r.desy     <= sat_quo(c_last.lay[DW-1] != flip, ov_dy, q_dy);
      s8_r.rdx      <= rdx;
      s8_r.rdy      <= rdy;

      s9_r.vld      <= s8_r.vld;
      s9_r.v        <= s8_r.v;
      s9_r.num      <= num_nxt;
      s9_r.lng      <= lng_nxt;
      s9_r.zs       <= (s8_r.v == '0);
      s9_r.low_norm <= s8_r.low_norm;
      s9_r.last     <= s8_r.last;
    end
  end

  // Yaw rate division.
  logic [DW-1:0] q_yaw;
  logic          ov_yaw;

  fcas_div u_div_yaw (
    .clk      (clk),
    .en       (en),
    .dividend ((2*DW)'(mag_of(s9_r.num)) << FB),
    .divisor  (mag_of(s9_r.v)),
    .quo      (q_yaw),
    .ovf      (ov_yaw)
  );

  end_t d_pipe_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) d_pipe_r[i] <= '0;
    end else if (en) begin
      d_pipe_r[0] <= s9_r;
      for (int i = 1; i < DIV_LAT; i++) d_pipe_r[i] <= d_pipe_r[i-1];
    end
  end

  end_t d_last;
  out_t res;

  assign d_last = d_pipe_r[DIV_LAT-1];

  always_comb begin
    res.zs   = d_last.zs;
    res.last = d_last.last;
    res.yaw  = sat_quo(d_last.num[DW-1] ^ d_last.v[DW-1], ov_yaw, q_yaw);
    res.lng  = d_last.lng;
    if (d_last.zs || d_last.low_norm) begin
      res.yaw = '0;
      res.lng = '0;
    end
  end

  // Two-entry output buffer.
  out_t ent_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic push, pop;

  assign push      = en && d_last.vld;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= res;
    end
  end

  assign out_yaw_rate   = ent_r[rd_ptr_r].yaw;
  assign out_long_accel = ent_r[rd_ptr_r].lng;
  assign out_zero_speed = ent_r[rd_ptr_r].zs;
  assign out_last_out   = ent_r[rd_ptr_r].last;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 2'd1 ||
         cnt_r == $past(cnt_r) - 2'd1))
    else $error("output buffer count jumped");

  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_speed) |-> (out_yaw_rate == '0 && out_long_accel == '0))
    else $error("zero speed transaction with nonzero outputs");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && s9_r.vld) |=> s9_r.vld)
    else $error("stalled stage lost its transaction");

endmodule

`default_nettype wire

>>> src/fcas_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on fcas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcas_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [2*fcas_pkg::DW-1:0]     dividend,
  input  logic [fcas_pkg::DW-1:0]       divisor,
  output logic [fcas_pkg::DW-1:0]       quo,
  output logic                          ovf
);
  import fcas_pkg::*;

  logic [DW-1:0] rem_r [DIV_LAT];
  logic [DW-1:0] lo_r  [DIV_LAT];
  logic [DW-1:0] quo_r [DIV_LAT];
  logic [DW-1:0] den_r [DIV_LAT];
  logic          ovf_r [DIV_LAT];

  logic [DW-1:0] rem_in [DIV_LAT];
  logic [DW-1:0] lo_in  [DIV_LAT];
  logic [DW-1:0] quo_in [DIV_LAT];
  logic [DW-1:0] den_in [DIV_LAT];
  logic          ovf_in [DIV_LAT];
  logic          ov0;

  assign ov0 = dividend[2*DW-1:DW] >= divisor;

  always_comb begin
    rem_in[0] = ov0 ? '0 : dividend[2*DW-1:DW];
    lo_in[0]  = dividend[DW-1:0];
    quo_in[0] = '0;
    den_in[0] = divisor;
    ovf_in[0] = ov0;
    for (int k = 1; k < DIV_LAT; k++) begin
      rem_in[k] = rem_r[k-1];
      lo_in[k]  = lo_r[k-1];
      quo_in[k] = quo_r[k-1];
      den_in[k] = den_r[k-1];
      ovf_in[k] = ovf_r[k-1];
    end
  end

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      t    = {rem_in[k], lo_in[k][DW-1]};
      diff = t - {1'b0, den_in[k]};
      ge   = t >= {1'b0, den_in[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        lo_r[k]  <= lo_in[k] << 1;
        quo_r[k] <= {quo_in[k][DW-2:0], ge};
        den_r[k] <= den_in[k];
        ovf_r[k] <= ovf_in[k];
      end
    end
  end

  assign quo = quo_r[DIV_LAT-1];
  assign ovf = ovf_r[DIV_LAT-1];

endmodule

`default_nettype wire

>>> src/fcas_sqrt.sv
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on fcas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcas_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*fcas_pkg::DW-1:0] rad,
  output logic [fcas_pkg::DW-1:0]   root
);
  import fcas_pkg::*;

  logic [DW:0]     rem_r [SQRT_LAT];
  logic [2*DW-1:0] x_r   [SQRT_LAT];
  logic [DW-1:0]   q_r   [SQRT_LAT];

  logic [DW:0]     rem_in [SQRT_LAT];
  logic [2*DW-1:0] x_in   [SQRT_LAT];
  logic [DW-1:0]   q_in   [SQRT_LAT];

  always_comb begin
    rem_in[0] = '0;
    x_in[0]   = rad;
    q_in[0]   = '0;
    for (int k = 1; k < SQRT_LAT; k++) begin
      rem_in[k] = rem_r[k-1];
      x_in[k]   = x_r[k-1];
      q_in[k]   = q_r[k-1];
    end
  end

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [DW+2:0] r2;
    logic [DW+2:0] trial;
    logic [DW+2:0] diff;
    logic          ge;

    always_comb begin
      r2    = {rem_in[k], x_in[k][2*DW-1:2*DW-2]};
      trial = {1'b0, q_in[k], 2'b01};
      diff  = r2 - trial;
      ge    = r2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW:0] : r2[DW:0];
        x_r[k]   <= x_in[k] << 2;
        q_r[k]   <= {q_in[k][DW-2:0], ge};
      end
    end
  end

  assign root = q_r[SQRT_LAT-1];

endmodule

`default_nettype wire

>>> test/fcas_checker.sv
// Scoreboard for the friction circle acceleration selector: mirrors the config
// registers, predicts each result from the accepted inputs and compares in order.
// Depends on fcas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcas_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [fcas_pkg::DW-1:0] in_speed,
  input  logic signed [fcas_pkg::DW-1:0] in_grad_heading,
  input  logic signed [fcas_pkg::DW-1:0] in_grad_speed,
  input  logic                           in_last_point,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [fcas_pkg::DW-1:0] out_yaw_rate,
  input  logic signed [fcas_pkg::DW-1:0] out_long_accel,
  input  logic                           out_zero_speed,
  input  logic                           out_last_out,
  input  logic                           cfg_wr_en,
  input  logic [fcas_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fcas_pkg::CW-1:0]        cfg_wdata,
  output int                             errors,
  output int                             pending
);
  import fcas_pkg::*;

  typedef struct {
    logic signed [DW-1:0] yaw;
    logic signed [DW-1:0] lng;
    logic                 zs;
    logic                 last;
  } accel_t;

  accel_t accel_q[$];

  logic          maximize;
  logic [63:0]   radius;
  logic [63:0]   long_cap;
  logic [63:0]   power_ratio;
  logic [63:0]   lat_coef;

  function automatic logic [63:0] absv(input longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint clamp_q(input bit neg, input logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint q_quot(input longint a, input longint b);
    logic [127:0] n;
    n = {64'b0, absv(a)} << FB;
    return clamp_q((a < 0) != (b < 0), n / {64'b0, absv(b)});
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] x);
    logic [63:0]  r;
    logic [127:0] c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'b0, r | (64'b1 << b)};
      if (c * c <= x) r = c[63:0];
    end
    return r;
  endfunction

  function automatic longint circle_leg(input logic [63:0] a, input longint b);
    logic [127:0] a2;
    logic [127:0] b2;
    a2 = {64'b0, a} * {64'b0, a};
    b2 = {64'b0, absv(b)} * {64'b0, absv(b)};
    if (b2 >= a2) return 0;
    return longint'(floor_root(a2 - b2));
  endfunction

  function automatic accel_t select_accel(input longint v, input longint gh, input longint gs,
                                          input logic last);
    accel_t       r;
    longint       lay, desx, desy, capx, capy, vv, t;
    logic [63:0]  norm, ady;
    bit           flip;
    r.yaw = '0;
    r.lng = '0;
    r.zs = 1'b0;
    r.last = last;
    if (v == 0) begin
      r.zs = 1'b1;
      return r;
    end
    lay = q_quot(gh, v);
    norm = floor_root({64'b0, absv(gs)} * {64'b0, absv(gs)} +
                      {64'b0, absv(lay)} * {64'b0, absv(lay)});
    if (norm > 64'(WMAX)) norm = 64'(WMAX);
    if (norm < 64'(EPS)) return r;
    flip = !maximize;
    desx = clamp_q((gs < 0) != flip, ({64'b0, absv(gs)} * {64'b0, radius}) / {64'b0, norm});
    desy = clamp_q((lay < 0) != flip, ({64'b0, absv(lay)} * {64'b0, radius}) / {64'b0, norm});
    capx = q_quot(longint'(power_ratio), v);
    vv = clamp_q(0, ({64'b0, absv(v)} * {64'b0, absv(v)}) >> FB);
    capy = clamp_q(0, ({64'b0, lat_coef} * {64'b0, 64'(vv)}) >> FB);
    ady = absv(desy);
    if (longint'(long_cap) < capx) capx = longint'(long_cap);
    if (desx > capx) begin
      if (ady < 64'(capy)) begin
        t = circle_leg(radius, capx);
        if (t < capy) capy = t;
      end
      r.yaw = DW'(q_quot(desy < 0 ? -capy : capy, v));
      r.lng = DW'(capx);
    end else if (ady > 64'(capy)) begin
      if (desx > 0) begin
        t = circle_leg(radius, capy);
        if (t < capx) capx = t;
        r.lng = DW'(capx);
      end else begin
        r.lng = DW'(-circle_leg(radius, capy));
      end
      r.yaw = DW'(q_quot(desy < 0 ? -capy : capy, v));
    end else begin
      r.yaw = DW'(q_quot(desy, v));
      r.lng = DW'(capx);
    end
    return r;
  endfunction

  assign pending = accel_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    accel_t e;
    if (!rst_n) begin
      maximize <= 1'b0;
      radius <= '0;
      long_cap <= '0;
      power_ratio <= '0;
      lat_coef <= '0;
      accel_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (accel_q.size() == 0) begin
          $error("unexpected transaction: yaw_rate %0d long_accel %0d",
                 out_yaw_rate, out_long_accel);
          errors++;
        end else begin
          e = accel_q.pop_front();
          if (out_yaw_rate !== e.yaw) begin
            $error("yaw_rate expected %0d actual %0d", e.yaw, out_yaw_rate);
            errors++;
          end
          if (out_long_accel !== e.lng) begin
            $error("long_accel expected %0d actual %0d", e.lng, out_long_accel);
            errors++;
          end
          if (out_zero_speed !== e.zs) begin
            $error("zero_speed expected %0d actual %0d", e.zs, out_zero_speed);
            errors++;
          end
          if (out_last_out !== e.last) begin
            $error("last_out expected %0d actual %0d", e.last, out_last_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        accel_q.push_back(select_accel(longint'(in_speed), longint'(in_grad_heading),
                                       longint'(in_grad_speed), in_last_point));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DIST_MODE: maximize <= cfg_wdata[0];
          REG_MAX_ACCEL: radius <= 64'(cfg_wdata);
          REG_MAX_LONG:  long_cap <= 64'(cfg_wdata);
          REG_POWER:     power_ratio <= 64'(cfg_wdata);
          REG_LAT_COEF:  lat_coef <= 64'(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> test/tb_friction_circle_accel_select.sv
// Testbench top for the friction circle acceleration selector: clock, reset,
// config phases, directed and random stimulus, and the verdict.
// Depends on fcas_pkg, friction_circle_accel_select and fcas_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_friction_circle_accel_select;
  import fcas_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CW-1:0] CFG_MAX = {CW{1'b1}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] in_speed = '0;
  logic signed [DW-1:0] in_grad_heading = '0;
  logic signed [DW-1:0] in_grad_speed = '0;
  logic                 in_last_point = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] out_yaw_rate;
  logic signed [DW-1:0] out_long_accel;
  logic                 out_zero_speed;
  logic                 out_last_out;
  logic                 cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CW-1:0]        cfg_wdata = '0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  bit                   hold_req = 0;
  bit                   steady = 0;

  always #2 clk = ~clk;

  friction_circle_accel_select uut (.*);

  fcas_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("friction_circle_accel_select test failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_point(input logic [DW-1:0] v, input logic [DW-1:0] gh,
                            input logic [DW-1:0] gs, input logic last);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_speed <= v;
    in_grad_heading <= gh;
    in_grad_speed <= gs;
    in_last_point <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_limits(input logic mode, input logic [CW-1:0] a, input logic [CW-1:0] lc,
                             input logic [CW-1:0] p, input logic [CW-1:0] k);
    write_reg(REG_DIST_MODE, CW'(mode));
    write_reg(REG_MAX_ACCEL, a);
    write_reg(REG_MAX_LONG, lc);
    write_reg(REG_POWER, p);
    write_reg(REG_LAT_COEF, k);
  endtask

  function automatic logic [DW-1:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return DW'($signed($urandom_range(0, 1 << 12)) - 2048);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0001;
          default: return 32'h0;
        endcase
      end
      default: return DW'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_limit();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 1 << 21));
      default: return CW'($urandom_range(1 << 14, 1 << 20));
    endcase
  endfunction

  task automatic random_points(input int count);
    logic [DW-1:0] v;
    for (int i = 0; i < count; i++) begin
      v = ($urandom_range(0, 19) == 0) ? '0 : rand_q();
      send_point(v, rand_q(), rand_q(), 1'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    random_points(30);
    drain();

    load_limits(1'b1, CW'(32'h0009_CCCC), CW'(32'h0004_0000), CW'(32'h0064_0000),
                CW'(32'h0000_4000));
    write_reg(REG_SPARE_LO, CFG_MAX);
    write_reg(REG_SPARE_HI, '0);
    send_point(32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0000_8000, 32'h0, 32'h0, 1'b1);
    send_point(32'h0001_0000, 32'h0, 32'h0000_0020, 1'b0);
    send_point(32'h0001_0000, 32'h0, 32'h0000_0041, 1'b0);
    send_point(32'hFFF6_0000, 32'h0001_0000, 32'h0002_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_point(32'h000A_0000, 32'h0, 32'h0005_0000, 1'b0);
    send_point(32'h000A_0000, 32'h0, 32'hFFFB_0000, 1'b0);
    send_point(32'h000A_0000, 32'h0050_0000, 32'h0, 1'b0);
    send_point(32'h000A_0000, 32'hFFB0_0000, 32'h0, 1'b1);
    send_point(32'h0002_0000, 32'h0010_0000, 32'h0010_0000, 1'b0);
    send_point(32'h0032_0000, 32'h0001_0000, 32'h0100_0000, 1'b0);
    drain();

    load_limits(1'b0, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
    send_point(32'h000A_0000, 32'h0050_0000, 32'h0005_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b1);
    send_point(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    random_points(200);
    drain();

    load_limits(1'b1, CW'(32'h0009_CCCC), CW'(32'h0003_0000), CW'(32'h0064_0000),
                CW'(32'h0000_2000));
    steady = 1;
    random_points(150);
    steady = 0;
    hold_req = 1;
    random_points(60);
    random_points(100);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      load_limits(1'($urandom), rand_limit(), rand_limit(), rand_limit(), rand_limit());
      random_points(220);
      drain();
    end

    load_limits(1'b0, '0, '0, '0, '0);
    random_points(30);
    drain();

    if (errors == 0) begin
      $display("friction_circle_accel_select test passed");
    end else begin
      $display("friction_circle_accel_select test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
